FILE: design/smt_pkg.sv
// Shared types and constants for the sorted multiset table.
// Depends on nothing; every file but smt_ram imports it.
package smt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int COUNT_BITS    = 16;
	localparam int KEY_BITS      = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	// request queue between front and back, depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// request codes on the input channel
	localparam logic [1:0] REQ_SEARCH = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_ERASE  = 2'd2;

	typedef logic [COUNT_BITS-1:0]      count_t;
	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]           idx_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_SEARCH,
		OP_ADD,
		OP_ERASE
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		key_t     key;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  item;
	} queue_head_t;

endpackage

FILE: design/smt_if.sv
// Handshake channels of the sorted multiset table: request and response.
// Depends on smt_pkg for field types.
interface smt_req_if
	import smt_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	key_t       key_value;

	modport source (output valid, output req_type, output key_value, input ready);
	modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface smt_rsp_if;
	logic valid;
	logic ready;
	logic success;
	logic capacity_error;

	modport source (output valid, output success, output capacity_error, input ready);
	modport sink   (input valid, input success, input capacity_error, output ready);
endinterface

FILE: design/smt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module smt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: design/smt_front.sv
// Front end: accept requests, classify them and hold them in a short queue.
// Depends on smt_pkg and smt_if.
module smt_front
	import smt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	smt_req_if.sink     req,
	input  logic        clear_busy,
	output queue_head_t head,
	input  logic        pop
);
	op_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	op_t               cls;
	logic              push;
	logic              take;

	always_comb begin
		unique case (req.req_type)
			REQ_SEARCH: cls.kind = OP_SEARCH;
			REQ_ADD:    cls.kind = OP_ADD;
			REQ_ERASE:  cls.kind = OP_ERASE;
			default:    cls.kind = OP_NOP;
		endcase
		cls.key = req.key_value;
	end

	assign req.ready  = (cnt_q != QCNT_W'(QDEPTH)) && !clear_busy;
	assign push       = req.valid && req.ready;
	assign take       = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

FILE: design/smt_back.sv
// Back end: scan the key and count memories, apply the request, post the result.
// Depends on smt_pkg, smt_if and smt_ram.
module smt_back
	import smt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	output logic        clear_busy,
	smt_rsp_if.source   rsp
);
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;

	logic [2:0] state_q;
	idx_t       clr_idx_q;
	idx_t       iss_idx_q;
	logic       iss_done_q;
	logic       rd_vld_s1;
	idx_t       rd_idx_s1;
	op_t        cur_q;
	logic       hit_found_q;
	idx_t       hit_idx_q;
	count_t     hit_cnt_q;
	logic       free_found_q;
	idx_t       free_idx_q;
	logic       rsp_valid_q;
	logic       rsp_ok_q;
	logic       rsp_cap_q;

	key_t   key_rdata;
	count_t cnt_rdata;
	logic   rd_en;
	logic   live;
	logic   match;
	logic   out_free;
	logic   fire;

	logic   upd_en;
	idx_t   upd_idx;
	count_t upd_cnt;
	logic   key_we;
	logic   res_ok;
	logic   res_cap;

	logic   cnt_we;
	idx_t   cnt_waddr;
	count_t cnt_wdata;

	assign clear_busy = (state_q == ST_CLEAR);
	assign pop        = (state_q == ST_IDLE) && head.valid;
	assign rd_en      = (state_q == ST_SCAN) && !iss_done_q;
	assign live       = (cnt_rdata != '0);
	assign match      = live && (key_rdata == cur_q.key);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign fire       = (state_q == ST_DECIDE) && out_free;

	// outcome of the request once the scan has finished
	always_comb begin
		upd_en  = 1'b0;
		upd_idx = hit_idx_q;
		upd_cnt = hit_cnt_q;
		key_we  = 1'b0;
		res_ok  = 1'b0;
		res_cap = 1'b0;
		unique case (cur_q.kind)
			OP_SEARCH: res_ok = hit_found_q;
			OP_ADD: begin
				if (hit_found_q) begin
					if (hit_cnt_q == COUNT_MAX) begin
						res_cap = 1'b1;
					end else begin
						upd_en  = 1'b1;
						upd_cnt = hit_cnt_q + 1'b1;
						res_ok  = 1'b1;
					end
				end else if (free_found_q) begin
					upd_en  = 1'b1;
					upd_idx = free_idx_q;
					upd_cnt = COUNT_BITS'(1);
					key_we  = 1'b1;
					res_ok  = 1'b1;
				end else begin
					res_cap = 1'b1;
				end
			end
			OP_ERASE: begin
				if (hit_found_q) begin
					upd_en  = 1'b1;
					upd_cnt = hit_cnt_q - 1'b1;
					res_ok  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// count memory is written by the clearing pass or by an update
	always_comb begin
		if (state_q == ST_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_idx_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = fire && upd_en;
			cnt_waddr = upd_idx;
			cnt_wdata = upd_cnt;
		end
	end

	smt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (TABLE_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (fire && key_we),
		.waddr (upd_idx),
		.wdata (cur_q.key),
		.re    (rd_en),
		.raddr (iss_idx_q),
		.rdata (key_rdata)
	);

	smt_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (TABLE_ENTRIES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (iss_idx_q),
		.rdata (cnt_rdata)
	);

	assign rsp.valid          = rsp_valid_q;
	assign rsp.success        = rsp_ok_q;
	assign rsp.capacity_error = rsp_cap_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
		end
		rd_idx_s1 <= iss_idx_q;
		if (rd_vld_s1 && match && !hit_found_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_cnt_q <= cnt_rdata;
		end
		if (rd_vld_s1 && !live && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (fire) begin
			rsp_ok_q  <= res_ok;
			rsp_cap_q <= res_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			iss_idx_q    <= '0;
			iss_done_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_vld_s1 && match) begin
				hit_found_q <= 1'b1;
			end
			if (rd_vld_s1 && !live) begin
				free_found_q <= 1'b1;
			end
			if (rd_en) begin
				if (iss_idx_q == LAST_IDX) begin
					iss_done_q <= 1'b1;
				end else begin
					iss_idx_q <= iss_idx_q + 1'b1;
				end
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						iss_idx_q    <= '0;
						iss_done_q   <= 1'b0;
						// unused codes need no scan
						state_q <= (head.item.kind == OP_NOP) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: design/sorted_multiset_table.sv
// Sorted multiset table: per request the back end pops it, reads every entry in
// turn (unused codes skip this scan), compares after the last read and decides.
// The back end works on one request at a time, set by the scan over the single read
// port of the key and count memories. After arst_n the count memory is cleared entry
// by entry, and no request is taken while it is cleared.
module sorted_multiset_table
	import smt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	smt_req_if.sink   req,
	smt_rsp_if.source rsp
);
	// Queue head and pop form the boundary between the two halves: the front
	// keeps taking transfers while its queue has room and the back is busy
	// scanning, and the back's output register lets a finished result wait
	// without stalling the scan of the next request.
	queue_head_t head;
	logic        pop;
	logic        clear_busy;

	// Front: decode the request code, drop it into the queue. Hold off
	// transfers while the count memory is being cleared.
	smt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.clear_busy (clear_busy),
		.head       (head),
		.pop        (pop)
	);

	// Back: walk every entry (not for unused codes), note the first live match
	// and the lowest free entry, then update at most one entry and post success / capacity_error.
	smt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.clear_busy (clear_busy),
		.rsp        (rsp)
	);
endmodule
